// ===== rtl/core/aos_pkg.sv =====
`default_nettype none
package aos_pkg;

	localparam int ZONES_DEF      = 10;
	localparam int OVERSAMPLE_DEF = 8;

	localparam int CH_W      = 4;
	localparam int SAMPLE_W  = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 4;
	localparam int MV_W      = 16;
	localparam int RATIO_W   = 32;

	// Shared divider: widest numerator is mean*ref*100*65536, widest divisor fs*supply.
	localparam int NUM_W = 51;
	localparam int DEN_W = 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [SAMPLE_W-1:0] MEAN_MAX      = 12'd4095;
	localparam logic [CFG_W-1:0]    SUPPLY_DEF_MV = 16'd12000;

	localparam logic [CH_W-1:0] CH_RAIL   = 4'd10;
	localparam logic [CH_W-1:0] CH_BATT   = 4'd11;
	localparam logic [CH_W-1:0] CH_TAMPER = 4'd12;
	localparam logic [CH_W-1:0] CH_TEMP   = 4'd13;
	localparam logic [CH_W-1:0] CH_VREF   = 4'd14;
	localparam logic [CH_W-1:0] CH_NONE   = 4'd15;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_MV     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_GAIN  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BATT_GAIN  = 4'd3;

	typedef struct packed {
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] full_scale;
		logic [CFG_W-1:0] ref_mv;
		logic [CFG_W-1:0] rail_gain;
		logic [CFG_W-1:0] batt_gain;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MUL_A,
		ST_MUL_B,
		ST_MV_GO,
		ST_MV_WAIT,
		ST_RAT_GO,
		ST_RAT_WAIT,
		ST_OUT
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/aos_front.sv =====
`default_nettype none
module aos_front import aos_pkg::*; #(
	parameter int ZONES = ZONES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CH_W-1:0]     channel,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                pop,
	output logic                     q_valid,
	output item_t                    q_item
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              accept, keep, push, do_pop;

	// Items on the unused code and on zones that are not fitted never enter the queue.
	assign keep = (channel != CH_NONE)
		&& !((channel < CH_RAIL) && (channel >= CH_W'(ZONES)));
	assign in_stall = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;
	assign push     = accept && keep;
	assign q_valid  = (count_q != '0);
	assign do_pop   = pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{ch: channel, sample: sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/aos_div.sv =====
`default_nettype none
module aos_div import aos_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   rem_sh, rem_sub;
	logic             fits;

	// Restoring division, one quotient bit per cycle.
	assign rem_sh  = {rem_q, quot_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quot: quot_q};

endmodule
`default_nettype wire

// ===== rtl/core/aos_back.sv =====
`default_nettype none
module aos_back import aos_pkg::*; #(
	parameter int ZONES      = ZONES_DEF,
	parameter int OVERSAMPLE = OVERSAMPLE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  cfg_t                      cfg,
	input  wire logic                 q_valid,
	input  item_t                     q_item,
	output logic                      pop,
	output div_req_t                  div_req,
	input  div_rsp_t                  div_rsp,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CH_W-1:0]           out_channel,
	output logic [SAMPLE_W-1:0]       mean_code,
	output logic [MV_W-1:0]           millivolts,
	output logic [RATIO_W-1:0]        ratio_q16,
	output logic                      last
);

	localparam int CAP   = OVERSAMPLE * 4095;
	localparam int SUM_W = $clog2(CAP + 1);
	localparam int RC_W  = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
	localparam int P1_W  = 28;
	localparam int MVN_W = 44;
	localparam int RN_W  = 35;
	localparam int NCH   = 15;
	// Mean by reciprocal multiplication; the shift is wide enough that the
	// quotient is exact for every sum up to the cap.
	localparam int RSH    = SUM_W + $clog2(OVERSAMPLE);
	localparam int RCP_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam longint unsigned RECIP =
		((64'd1 << RSH) + 64'(OVERSAMPLE) - 64'd1) / 64'(OVERSAMPLE);

	back_state_t       state_q, state_d;
	logic [SUM_W-1:0]  sums_q [NCH];
	logic [RC_W-1:0]   row_q;
	logic [CH_W-1:0]   c_q, c_next, rd_idx;
	logic [MV_W-1:0]   rail_mv_q, mv_q;
	logic [SAMPLE_W-1:0] m_q;
	logic [PROD_W-1:0] mprod_q;
	logic [P1_W-1:0]   p1_q;
	logic [MVN_W-1:0]  mvnum_q;
	logic [RN_W-1:0]   rnum_q;
	logic [DEN_W-1:0]  rden_q;
	logic [RATIO_W-1:0] ratio_q;

	logic [SUM_W-1:0]  sum_rd, sum_sat;
	logic [SUM_W:0]    sum_add;
	logic [CFG_W-1:0]  fs_eff, supply, den_sel, gain;
	logic              is_zone, is_rb, out_free, out_load, block_end;
	logic [MV_W-1:0]   mv_sat;
	logic [RATIO_W-1:0] ratio_sat;

	assign fs_eff  = (cfg.full_scale == '0) ? CFG_W'(1) : cfg.full_scale;
	assign supply  = (rail_mv_q != '0) ? rail_mv_q : SUPPLY_DEF_MV;
	assign is_zone = (c_q < CH_RAIL);
	assign is_rb   = (c_q == CH_RAIL) || (c_q == CH_BATT);
	assign den_sel = is_zone ? supply : (is_rb ? SUPPLY_DEF_MV : CFG_W'(1));
	assign gain    = (c_q == CH_BATT) ? cfg.batt_gain : cfg.rail_gain;
	assign c_next  = (c_q == CH_W'(ZONES - 1)) ? CH_RAIL : c_q + 1'b1;

	assign rd_idx  = (state_q == ST_IDLE) ? q_item.ch : c_q;
	assign sum_rd  = sums_q[rd_idx];
	assign sum_add = {1'b0, sum_rd} + (SUM_W+1)'(q_item.sample);
	assign sum_sat = (sum_add > (SUM_W+1)'(CAP)) ? SUM_W'(CAP) : sum_add[SUM_W-1:0];

	assign mv_sat    = (div_rsp.quot[NUM_W-1:MV_W] != '0) ? '1 : div_rsp.quot[MV_W-1:0];
	assign ratio_sat = (div_rsp.quot[NUM_W-1:RATIO_W] != '0) ? '1
		: div_rsp.quot[RATIO_W-1:0];

	assign out_free  = !out_valid || !out_stall;
	assign block_end = (q_item.ch == CH_VREF) && (row_q == RC_W'(OVERSAMPLE - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && block_end) begin
					state_d = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
			ST_MEAN_WAIT: state_d = ST_MUL_A;
			ST_MUL_A:     state_d = ST_MUL_B;
			ST_MUL_B:     state_d = ST_MV_GO;
			ST_MV_GO:     state_d = ST_MV_WAIT;
			ST_MV_WAIT:   if (div_rsp.done) state_d = ST_RAT_GO;
			ST_RAT_GO:    state_d = ST_RAT_WAIT;
			ST_RAT_WAIT:  if (div_rsp.done) state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = (c_q == CH_TEMP) ? ST_IDLE : ST_MEAN_GO;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		div_req  = '{start: 1'b0, num: '0, den: '0};
		unique case (state_q)
			ST_IDLE: pop = q_valid;
			ST_MV_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(mvnum_q);
				div_req.den   = is_rb ? DEN_W'({fs_eff, 8'd0}) : DEN_W'(fs_eff);
			end
			ST_RAT_GO: begin
				div_req = '{start: 1'b1, num: NUM_W'({rnum_q, 16'd0}), den: rden_q};
			end
			ST_OUT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN_GO) begin
			mprod_q <= PROD_W'(sum_rd) * PROD_W'(RECIP);
		end
		if (state_q == ST_MEAN_WAIT) begin
			m_q <= (mprod_q[PROD_W-1:RSH+SAMPLE_W] != '0) ? MEAN_MAX
				: mprod_q[RSH +: SAMPLE_W];
		end
		if (state_q == ST_MUL_A) begin
			p1_q   <= P1_W'(m_q) * P1_W'(cfg.ref_mv);
			rden_q <= DEN_W'(fs_eff) * DEN_W'(den_sel);
		end
		if (state_q == ST_MUL_B) begin
			mvnum_q <= is_rb ? MVN_W'(p1_q) * MVN_W'(gain) : MVN_W'(p1_q);
			rnum_q  <= is_zone ? RN_W'(p1_q) * RN_W'(100)
				: (is_rb ? RN_W'(p1_q) : RN_W'(m_q));
		end
		if (state_q == ST_MV_WAIT && div_rsp.done) begin
			mv_q <= mv_sat;
		end
		if (state_q == ST_RAT_WAIT && div_rsp.done) begin
			ratio_q <= ratio_sat;
		end
		if (out_load) begin
			out_channel <= c_q;
			mean_code   <= m_q;
			millivolts  <= mv_q;
			ratio_q16   <= ratio_q;
			last        <= (c_q == CH_TEMP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_q     <= '0;
			c_q       <= '0;
			rail_mv_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < NCH; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pop && q_valid) begin
				if (q_item.ch == CH_VREF) begin
					row_q <= block_end ? '0 : row_q + 1'b1;
					c_q   <= '0;
				end else begin
					sums_q[q_item.ch] <= sum_sat;
				end
			end
			// Zones of this block are already done when the rail finishes.
			if (state_q == ST_MV_WAIT && div_rsp.done && c_q == CH_RAIL) begin
				rail_mv_q <= mv_sat;
			end
			if (out_load) begin
				out_valid <= 1'b1;
				c_q       <= c_next;
				if (c_q == CH_TEMP) begin
					for (int i = 0; i < NCH; i++) begin
						sums_q[i] <= '0;
					end
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_last_on_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_channel == CH_TEMP)
		else $error("last flag on a result other than the final channel");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && c_q == CH_TEMP |=> state_q == ST_IDLE && row_q == '0)
		else $error("block did not close after the final result");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/multichannel_adc_oversample_scaler.sv =====
// Channel  Handshake             Payload
// input    in_valid / in_stall   channel, sample
// result   out_valid / out_stall out_channel, mean_code, millivolts, ratio_q16, last
// config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Items are taken off the input queue while the back end is idle; sums update as each is popped.
// The item that closes a block starts ZONES+4 results, each computed in steps:
//   two for the mean, two multiply steps, two divider passes, one to load.
// A four-entry queue holds conversions that arrive while a block is scaled.
// Reset clears sums, row count, rail millivolts and the registers to their defaults.
// A stalled result holds its register; the back end waits before loading the next.
`default_nettype none
module multichannel_adc_oversample_scaler import aos_pkg::*; #(
	parameter int ZONES      = ZONES_DEF,
	parameter int OVERSAMPLE = OVERSAMPLE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [CH_W-1:0]      channel,
	input  wire logic [SAMPLE_W-1:0]  sample,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CH_W-1:0]           out_channel,
	output logic [SAMPLE_W-1:0]       mean_code,
	output logic [MV_W-1:0]           millivolts,
	output logic [RATIO_W-1:0]        ratio_q16,
	output logic                      last,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	cfg_t     cfg_q;
	logic     q_valid, pop;
	item_t    q_item;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Registers are always writable; writes to an unknown index are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{full_scale: 16'd4095, ref_mv: 16'd3300,
				rail_gain: 16'd256, batt_gain: 16'd256};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FULL_SCALE: cfg_q.full_scale <= cfg_data;
				REG_REF_MV:     cfg_q.ref_mv     <= cfg_data;
				REG_RAIL_GAIN:  cfg_q.rail_gain  <= cfg_data;
				REG_BATT_GAIN:  cfg_q.batt_gain  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end filters and queues conversions.
	aos_front #(.ZONES(ZONES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.channel(channel), .sample(sample),
		.pop(pop), .q_valid(q_valid), .q_item(q_item)
	);

	// The divider is shared by the millivolt and ratio steps.
	aos_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	// The back end accumulates and sequences the per-channel scaling.
	aos_back #(.ZONES(ZONES), .OVERSAMPLE(OVERSAMPLE)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_item(q_item), .pop(pop),
		.div_req(div_req), .div_rsp(div_rsp),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_channel(out_channel), .mean_code(mean_code),
		.millivolts(millivolts), .ratio_q16(ratio_q16), .last(last)
	);

endmodule
`default_nettype wire
